[rtl/core/mle_pkg.sv]
// mle_pkg: shared types and codes of the lattice exchange block
// item and result payload structs, kind and outcome codes, sequencer states
// no dependencies
`timescale 1ns / 1ps

package mle_pkg;

  // input item kinds
  localparam logic [2:0] KIND_SITE   = 3'd0;
  localparam logic [2:0] KIND_COUNT  = 3'd1;
  localparam logic [2:0] KIND_NEIGH  = 3'd2;
  localparam logic [2:0] KIND_FACTOR = 3'd3;
  localparam logic [2:0] KIND_EVENT  = 3'd4;
  localparam logic [2:0] KIND_QUERY  = 3'd5;

  // result outcomes
  localparam logic [1:0] OUT_NONE   = 2'd0;
  localparam logic [1:0] OUT_ACCEPT = 2'd1;
  localparam logic [1:0] OUT_REJECT = 2'd2;

  // fixed-point constants
  localparam int unsigned NFACT    = 8;
  localparam logic [16:0] ONE_FRAC = 17'h10000;
  localparam logic [19:0] PROP_MAX = 20'hFFFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] site;
    logic [2:0]  slot;
    logic [15:0] value;
    logic [15:0] rand_pick;
    logic [15:0] rand_accept;
  } mle_item_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [11:0] partner;
    logic [19:0] propensity;
  } mle_result_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_WSITE,
    S_WVAL,
    S_LOOKI,
    S_CHKI,
    S_A_NB,
    S_A_OCC,
    S_A_CNT,
    S_SEL,
    S_J_OCC,
    S_J_CHK,
    S_B_NB,
    S_B_OCC,
    S_B_CNT,
    S_RISE,
    S_MV1,
    S_MV2,
    S_DONE
  } mle_state_e;

endpackage

[rtl/core/mle_wrap.sv]
// mle_wrap: reduction of a 16-bit site index modulo SITES by reciprocal multiplication
// operand, quotient and remainder registered in turn; done rises with the remainder
// no package dependencies
`timescale 1ns / 1ps

module mle_wrap #(
  parameter int unsigned SITES = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [15:0]              value_i,
  output logic                     done_o,
  output logic [$clog2(SITES)-1:0] rem_o
);

  localparam int unsigned     SW      = $clog2(SITES);
  localparam int unsigned     SH      = 16 + SW;
  localparam longint unsigned RECIP   = ((64'd1 << SH) + 64'(SITES) - 64'd1) / 64'(SITES);
  localparam logic [16:0]     RECIP_W = 17'(RECIP);
  localparam logic [16:0]     SITES_W = 17'(SITES);

  logic          ld_q;
  logic          qv_q;
  logic          done_q;
  logic [15:0]   val_q;
  logic [15:0]   quo_q;
  logic [SW-1:0] rem_q;
  logic [32:0]   prod;
  logic [32:0]   back;

  // quotient estimate and its product with the modulus
  assign prod = 33'(val_q) * 33'(RECIP_W);
  assign back = 33'(quo_q) * 33'(SITES_W);

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_q   <= 1'b0;
      qv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      ld_q   <= start_i;
      qv_q   <= ld_q;
      done_q <= qv_q;
    end
  end

  // operand, quotient and remainder
  always_ff @(posedge clk_i) begin
    if (start_i) val_q <= value_i;
    if (ld_q) quo_q <= 16'(prod >> SH);
    if (qv_q) rem_q <= SW'(33'(val_q) - back);
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[rtl/core/metropolis_lattice_exchange.sv]
// metropolis_lattice_exchange: lattice-gas vacancy exchange with metropolis rule
// sequencer, lattice memories and factor table; uses mle_pkg and mle_wrap
`timescale 1ns / 1ps

// channel    signals                     transfer
// item in    start, busy, item_i         start high and busy low at a clock edge
// result     done_o, result_o            done_o high for one cycle, no stall
// config     cfg_we_i, cfg_wdata_i       cfg_we_i high at a clock edge
//
// one item at a time: a new item is taken only once the result of the last one is out.
// a neighbor write to a valid slot passes the modulo unit twice, every other item once;
// an event or query then walks the neighbor list of site i and of each vacant neighbor
// j it picks, one read at a time through the single read port of each lattice memory.
// after reset a clearing pass over all SITES addresses empties occupancy and counts;
// busy stays high meanwhile. results cannot be held off by the receiver.

module metropolis_lattice_exchange #(
  parameter int unsigned SITES     = 4096,
  parameter int unsigned MAX_NEIGH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  mle_pkg::mle_item_t  item_i,
  output logic                done_o,
  output mle_pkg::mle_result_t result_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);

  localparam int unsigned SW       = $clog2(SITES);
  localparam int unsigned KW       = $clog2(MAX_NEIGH);
  localparam int unsigned CW       = $clog2(MAX_NEIGH + 1);
  localparam int unsigned NB_DEPTH = SITES * (2 ** KW);

  mle_pkg::mle_state_e  state_q, state_d;
  mle_pkg::mle_item_t   item_q;
  mle_pkg::mle_result_t res_q;

  logic          zt_q;
  logic [SW-1:0] clr_q;
  logic [15:0]   fact_q [mle_pkg::NFACT];

  logic [SW-1:0] i_q, j_q;
  logic [CW-1:0] cnt_i_q, cnt_j_q, m_q, k_q, eb_q, ea_q;
  logic [20:0]   sum_q;

  // lattice memories
  logic          occ_mem [SITES];
  logic [CW-1:0] cnt_mem [SITES];
  logic [SW-1:0] nb_mem  [NB_DEPTH];
  logic          occ_rd_q;
  logic [CW-1:0] cnt_rd_q;
  logic [SW-1:0] nb_rd_q;

  logic          occ_we, occ_wdata, occ_re;
  logic [SW-1:0] occ_waddr, occ_raddr;
  logic          cnt_we, cnt_re;
  logic [SW-1:0] cnt_waddr, cnt_raddr;
  logic [CW-1:0] cnt_wdata;
  logic          nb_we, nb_re;
  logic [SW+KW-1:0] nb_waddr, nb_raddr;
  logic          fact_we;

  logic          wrap_start, wrap_done;
  logic [15:0]   wrap_value;
  logic [SW-1:0] wrap_rem;

  logic          accept_in, is_event, slot_ok;
  logic [20:0]   pick_prod;
  logic [KW-1:0] kpick, slot_k;
  logic [CW-1:0] cnt_clamp, rise;
  logic [4:0]    rise5;
  logic [2:0]    fidx;
  logic          eff_occ, mv_ok;
  logic [16:0]   weight;
  logic [15:0]   j_wide;

  assign accept_in = start && !busy;
  assign is_event  = item_q.kind == mle_pkg::KIND_EVENT;
  assign slot_ok   = 5'({2'b00, item_q.slot}) < 5'(MAX_NEIGH);
  assign slot_k    = KW'({1'b0, item_q.slot});

  // neighbor slot picked from the random fraction
  assign pick_prod = 21'(MAX_NEIGH) * 21'(item_q.rand_pick);
  assign kpick     = pick_prod[16 +: KW];

  assign cnt_clamp = (item_q.value > 16'(MAX_NEIGH)) ? CW'(MAX_NEIGH) : item_q.value[CW-1:0];

  // neighbor occupancy as seen after the exchange
  assign eff_occ = (nb_rd_q == i_q) ? 1'b0 : ((nb_rd_q == j_q) ? 1'b1 : occ_rd_q);

  // energy rise, factor lookup and metropolis decision
  assign rise   = (ea_q > eb_q) ? (ea_q - eb_q) : '0;
  assign rise5  = 5'(rise);
  assign fidx   = (rise5 > 5'(mle_pkg::NFACT)) ? 3'(mle_pkg::NFACT - 1) : 3'(rise5 - 5'd1);
  assign mv_ok  = (rise == '0) || (!zt_q && (item_q.rand_accept <= fact_q[fidx]));
  assign weight = (rise == '0) ? mle_pkg::ONE_FRAC : (zt_q ? 17'd0 : {1'b0, fact_q[fidx]});
  assign j_wide = 16'(j_q);

  mle_wrap #(
    .SITES(SITES)
  ) u_wrap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(wrap_start),
    .value_i(wrap_value),
    .done_o (wrap_done),
    .rem_o  (wrap_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mle_pkg::S_CLEAR: if (clr_q == SW'(SITES - 1)) state_d = mle_pkg::S_IDLE;
      mle_pkg::S_IDLE:  if (start) state_d = mle_pkg::S_WSITE;
      mle_pkg::S_WSITE: begin
        if (wrap_done) begin
          case (item_q.kind)
            mle_pkg::KIND_NEIGH: state_d = slot_ok ? mle_pkg::S_WVAL : mle_pkg::S_DONE;
            mle_pkg::KIND_EVENT, mle_pkg::KIND_QUERY: state_d = mle_pkg::S_LOOKI;
            default: state_d = mle_pkg::S_DONE;
          endcase
        end
      end
      mle_pkg::S_WVAL:  if (wrap_done) state_d = mle_pkg::S_DONE;
      mle_pkg::S_LOOKI: state_d = mle_pkg::S_CHKI;
      mle_pkg::S_CHKI: begin
        if (!occ_rd_q || (is_event && !(CW'(kpick) < cnt_rd_q))) begin
          state_d = mle_pkg::S_DONE;
        end else begin
          state_d = mle_pkg::S_A_NB;
        end
      end
      mle_pkg::S_A_NB:  state_d = (m_q == cnt_i_q) ? mle_pkg::S_SEL : mle_pkg::S_A_OCC;
      mle_pkg::S_A_OCC: state_d = mle_pkg::S_A_CNT;
      mle_pkg::S_A_CNT: state_d = mle_pkg::S_A_NB;
      mle_pkg::S_SEL: begin
        if (!is_event && (k_q == cnt_i_q)) state_d = mle_pkg::S_DONE;
        else state_d = mle_pkg::S_J_OCC;
      end
      mle_pkg::S_J_OCC: state_d = mle_pkg::S_J_CHK;
      mle_pkg::S_J_CHK: begin
        if (occ_rd_q) state_d = is_event ? mle_pkg::S_DONE : mle_pkg::S_SEL;
        else state_d = mle_pkg::S_B_NB;
      end
      mle_pkg::S_B_NB:  state_d = (m_q == cnt_j_q) ? mle_pkg::S_RISE : mle_pkg::S_B_OCC;
      mle_pkg::S_B_OCC: state_d = mle_pkg::S_B_CNT;
      mle_pkg::S_B_CNT: state_d = mle_pkg::S_B_NB;
      mle_pkg::S_RISE: begin
        if (!is_event) state_d = mle_pkg::S_SEL;
        else state_d = mv_ok ? mle_pkg::S_MV1 : mle_pkg::S_DONE;
      end
      mle_pkg::S_MV1:   state_d = mle_pkg::S_MV2;
      mle_pkg::S_MV2:   state_d = mle_pkg::S_DONE;
      mle_pkg::S_DONE:  state_d = mle_pkg::S_IDLE;
      default:          state_d = mle_pkg::S_IDLE;
    endcase
  end

  // memory ports and modulo unit control
  always_comb begin
    occ_we     = 1'b0;
    occ_waddr  = i_q;
    occ_wdata  = 1'b0;
    occ_re     = 1'b0;
    occ_raddr  = nb_rd_q;
    cnt_we     = 1'b0;
    cnt_waddr  = wrap_rem;
    cnt_wdata  = cnt_clamp;
    cnt_re     = 1'b0;
    cnt_raddr  = nb_rd_q;
    nb_we      = 1'b0;
    nb_waddr   = {i_q, slot_k};
    nb_re      = 1'b0;
    nb_raddr   = {i_q, m_q[KW-1:0]};
    fact_we    = 1'b0;
    wrap_start = 1'b0;
    wrap_value = 16'(item_i.site);
    case (state_q)
      mle_pkg::S_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_q;
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        cnt_wdata = '0;
      end
      mle_pkg::S_IDLE: wrap_start = start;
      mle_pkg::S_WSITE: begin
        if (wrap_done) begin
          case (item_q.kind)
            mle_pkg::KIND_SITE: begin
              occ_we    = 1'b1;
              occ_waddr = wrap_rem;
              occ_wdata = item_q.value[0];
            end
            mle_pkg::KIND_COUNT:  cnt_we = 1'b1;
            mle_pkg::KIND_FACTOR: fact_we = 1'b1;
            mle_pkg::KIND_NEIGH: begin
              wrap_start = slot_ok;
              wrap_value = item_q.value;
            end
            default: ;
          endcase
        end
      end
      mle_pkg::S_WVAL: nb_we = wrap_done;
      mle_pkg::S_LOOKI: begin
        occ_re    = 1'b1;
        occ_raddr = i_q;
        cnt_re    = 1'b1;
        cnt_raddr = i_q;
      end
      mle_pkg::S_A_NB:  nb_re = m_q != cnt_i_q;
      mle_pkg::S_A_OCC: occ_re = 1'b1;
      mle_pkg::S_SEL: begin
        nb_re    = 1'b1;
        nb_raddr = {i_q, is_event ? kpick : k_q[KW-1:0]};
      end
      mle_pkg::S_J_OCC: begin
        occ_re = 1'b1;
        cnt_re = 1'b1;
      end
      mle_pkg::S_B_NB: begin
        nb_re    = m_q != cnt_j_q;
        nb_raddr = {j_q, m_q[KW-1:0]};
      end
      mle_pkg::S_B_OCC: occ_re = 1'b1;
      mle_pkg::S_MV1:   occ_we = 1'b1;
      mle_pkg::S_MV2: begin
        occ_we    = 1'b1;
        occ_waddr = j_q;
        occ_wdata = 1'b1;
      end
      default: ;
    endcase
  end

  // occupancy memory
  always_ff @(posedge clk_i) begin
    if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
    if (occ_re) occ_rd_q <= occ_mem[occ_raddr];
  end

  // neighbor count memory
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  // neighbor table, entries stored already wrapped
  always_ff @(posedge clk_i) begin
    if (nb_we) nb_mem[nb_waddr] <= wrap_rem;
    if (nb_re) nb_rd_q <= nb_mem[nb_raddr];
  end

  // factor table
  always_ff @(posedge clk_i) begin
    if (fact_we) fact_q[item_q.slot] <= item_q.value;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mle_pkg::S_CLEAR;
      clr_q   <= '0;
      zt_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == mle_pkg::S_CLEAR) clr_q <= clr_q + SW'(1);
      if (cfg_we_i) zt_q <= cfg_wdata_i;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      mle_pkg::S_IDLE: begin
        if (accept_in) begin
          item_q <= item_i;
          res_q  <= '0;
        end
      end
      mle_pkg::S_WSITE: if (wrap_done) i_q <= wrap_rem;
      mle_pkg::S_CHKI: begin
        cnt_i_q <= cnt_rd_q;
        m_q     <= '0;
        eb_q    <= '0;
        k_q     <= '0;
        sum_q   <= '0;
      end
      mle_pkg::S_A_CNT: begin
        if (!occ_rd_q) eb_q <= eb_q + CW'(1);
        m_q <= m_q + CW'(1);
      end
      mle_pkg::S_SEL: begin
        if (!is_event && (k_q == cnt_i_q)) begin
          res_q.propensity <= (sum_q > 21'(mle_pkg::PROP_MAX)) ? mle_pkg::PROP_MAX
                                                                : sum_q[19:0];
        end
      end
      mle_pkg::S_J_OCC: j_q <= nb_rd_q;
      mle_pkg::S_J_CHK: begin
        cnt_j_q <= cnt_rd_q;
        m_q     <= '0;
        ea_q    <= '0;
        if (occ_rd_q && !is_event) k_q <= k_q + CW'(1);
      end
      mle_pkg::S_B_CNT: begin
        if (!eff_occ) ea_q <= ea_q + CW'(1);
        m_q <= m_q + CW'(1);
      end
      mle_pkg::S_RISE: begin
        if (is_event) begin
          res_q.outcome <= mv_ok ? mle_pkg::OUT_ACCEPT : mle_pkg::OUT_REJECT;
          res_q.partner <= j_wide[11:0];
        end else begin
          sum_q <= sum_q + 21'(weight);
          k_q   <= k_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    busy     = state_q != mle_pkg::S_IDLE;
    done_o   = state_q == mle_pkg::S_DONE;
    result_o = res_q;
  end

  // checks
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> busy)
    else $error("accepted transfer did not raise busy");
  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
  a_outcome_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.outcome != 2'd3))
    else $error("undefined outcome code");
  a_prop_only_query : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.propensity != 20'd0)) |-> (result_o.outcome == mle_pkg::OUT_NONE))
    else $error("propensity given with a move outcome");

endmodule

[test/metropolis_lattice_exchange_tb.sv]
// metropolis_lattice_exchange_tb: self-checking bench for the lattice exchange block
// predicts every result from its own lattice copy and checks each result transfer
// depends on mle_pkg and metropolis_lattice_exchange
`timescale 1ns / 1ps

module metropolis_lattice_exchange_tb;

  localparam int unsigned NSITE = 4096;
  localparam int unsigned NNB   = 8;
  localparam int unsigned STALL_LIMIT = 20000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  mle_pkg::mle_item_t   item_i = '0;
  logic                 done_o;
  mle_pkg::mle_result_t result_o;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_wdata_i = 1'b0;

  // predictor copy of the lattice
  bit          occ_m [NSITE];
  int unsigned cnt_m [NSITE];
  logic [15:0] nbr_m [NSITE*NNB];
  bit          nbr_written [NSITE*NNB];
  logic [15:0] factor_m [mle_pkg::NFACT];
  bit          zero_temp_m;

  mle_pkg::mle_result_t expected_q[$];
  int unsigned site_pool[32];
  int          errors = 0;
  int          idle_pct = 0;
  int unsigned quiet_cycles = 0;

  metropolis_lattice_exchange dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned neighbor_of(int unsigned s, int unsigned k);
    return int'(nbr_m[s*NNB+k][11:0]);
  endfunction

  function automatic int unsigned energy_at(int unsigned s);
    int unsigned e = 0;
    if (!occ_m[s]) return 0;
    for (int unsigned k = 0; k < cnt_m[s]; k++)
      if (!occ_m[neighbor_of(s, k)]) e++;
    return e;
  endfunction

  // moves occupied i into vacant j, returns energy rise (0 if not uphill)
  function automatic int unsigned exchange_rise(int unsigned i, int unsigned j);
    int unsigned e0, e1;
    e0 = energy_at(i) + energy_at(j);
    occ_m[i] = 1'b0;
    occ_m[j] = 1'b1;
    e1 = energy_at(i) + energy_at(j);
    return (e1 > e0) ? e1 - e0 : 0;
  endfunction

  function automatic logic [15:0] factor_for(int unsigned rise);
    return factor_m[(rise > mle_pkg::NFACT) ? mle_pkg::NFACT-1 : rise-1];
  endfunction

  // applies one item to the lattice copy and returns its result
  function automatic mle_pkg::mle_result_t lattice_predict(mle_pkg::mle_item_t it);
    mle_pkg::mle_result_t r = '0;
    int unsigned i, j, k, rise;
    longint unsigned sum;
    bit ok;
    i = it.site;
    case (it.kind)
      mle_pkg::KIND_SITE:   occ_m[i] = it.value[0];
      mle_pkg::KIND_COUNT:  cnt_m[i] = (it.value > NNB) ? NNB : it.value;
      mle_pkg::KIND_NEIGH:  nbr_m[i*NNB+it.slot] = it.value;
      mle_pkg::KIND_FACTOR: factor_m[it.slot] = it.value;
      mle_pkg::KIND_EVENT: begin
        k = (NNB * it.rand_pick) >> 16;
        if (occ_m[i] && k < cnt_m[i]) begin
          j = neighbor_of(i, k);
          if (!occ_m[j]) begin
            rise = exchange_rise(i, j);
            if (rise == 0) ok = 1'b1;
            else if (zero_temp_m) ok = 1'b0;
            else ok = (it.rand_accept <= factor_for(rise));
            if (!ok) begin
              occ_m[i] = 1'b1;
              occ_m[j] = 1'b0;
            end
            r.outcome = ok ? mle_pkg::OUT_ACCEPT : mle_pkg::OUT_REJECT;
            r.partner = j[11:0];
          end
        end
      end
      mle_pkg::KIND_QUERY: begin
        if (occ_m[i]) begin
          sum = 0;
          for (k = 0; k < cnt_m[i]; k++) begin
            j = neighbor_of(i, k);
            if (!occ_m[j]) begin
              rise = exchange_rise(i, j);
              if (rise == 0) sum += mle_pkg::ONE_FRAC;
              else if (!zero_temp_m) sum += factor_for(rise);
              occ_m[i] = 1'b1;
              occ_m[j] = 1'b0;
            end
          end
          r.propensity = (sum > mle_pkg::PROP_MAX) ? mle_pkg::PROP_MAX : sum[19:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic mle_pkg::mle_item_t make_item(logic [2:0] kind, int unsigned site,
                                                   int unsigned slot, int unsigned value,
                                                   int unsigned pick, int unsigned acc);
    mle_pkg::mle_item_t it;
    it.kind = kind;
    it.site = site[11:0];
    it.slot = slot[2:0];
    it.value = value[15:0];
    it.rand_pick = pick[15:0];
    it.rand_accept = acc[15:0];
    return it;
  endfunction

  // one item transfer with random sender gaps; busy is stable at the falling edge
  task automatic send_item(mle_pkg::mle_item_t it);
    bit taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    expected_q.push_back(lattice_predict(it));
    if (it.kind == mle_pkg::KIND_NEIGH) nbr_written[it.site*NNB+it.slot] = 1'b1;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write while the block is idle
  task automatic set_zero_temp(bit v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    zero_temp_m = v;
  endtask

  function automatic int unsigned pool_neighbor();
    return site_pool[$urandom_range(0, 31)] + ($urandom_range(0, 15) << 12);
  endfunction

  // count write, first filling any unwritten list entries it exposes
  task automatic send_count(int unsigned s, int unsigned v);
    int unsigned eff;
    eff = (v > NNB) ? NNB : v;
    for (int unsigned k = 0; k < eff; k++)
      if (!nbr_written[s*NNB+k])
        send_item(make_item(mle_pkg::KIND_NEIGH, s, k, pool_neighbor(), 0, 0));
    send_item(make_item(mle_pkg::KIND_COUNT, s, 0, v, $urandom, $urandom));
  endtask

  task automatic test_directed();
    // factor table: extremes and mid values
    for (int unsigned f = 0; f < mle_pkg::NFACT; f++)
      send_item(make_item(mle_pkg::KIND_FACTOR, 0, f, (f == 0) ? 16'h0000 :
                          (f == 7) ? 16'hFFFF : f * 16'h2000, 0, 0));
    // site 0 lists sites 1..8, first entry with high bits that wrap
    for (int unsigned k = 0; k < NNB; k++)
      send_item(make_item(mle_pkg::KIND_NEIGH, 0, k, (k == 0) ? 16'hF001 : k + 1, 0, 0));
    send_count(0, 0);
    send_count(0, 9);
    // last site lists site 0 in every slot, count far too large
    for (int unsigned k = 0; k < NNB; k++)
      send_item(make_item(mle_pkg::KIND_NEIGH, NSITE-1, k, 16'h1000 * k, 0, 0));
    send_count(NSITE-1, 16'hFFFF);
    send_item(make_item(mle_pkg::KIND_EVENT, 5, 0, 0, 0, 0));          // vacant site
    send_item(make_item(mle_pkg::KIND_SITE, 0, 7, 16'hFFFF, 0, 0));
    send_item(make_item(mle_pkg::KIND_QUERY, 0, 0, 0, 0, 0));
    send_item(make_item(mle_pkg::KIND_SITE, 2, 0, 16'h0001, 0, 0));
    send_item(make_item(mle_pkg::KIND_EVENT, 0, 0, 0, 16'h2000, 0));   // neighbor occupied
    send_item(make_item(mle_pkg::KIND_EVENT, 0, 0, 0, 16'hFFFF, 16'hFFFF));
    send_item(make_item(mle_pkg::KIND_EVENT, 0, 0, 0, 0, 16'hFFFF));
    send_item(make_item(mle_pkg::KIND_EVENT, NSITE-1, 0, 0, 0, 0));
    send_item(make_item(mle_pkg::KIND_SITE, 3, 0, 16'hFFFE, 0, 0));
    send_item(make_item(6, 1, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF)); // unused kinds
    send_item(make_item(7, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int unsigned n, int pct, bit zt);
    int unsigned w, s;
    set_zero_temp(zt);
    idle_pct = pct;
    for (int unsigned c = 0; c < n; c++) begin
      w = $urandom_range(0, 99);
      s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NSITE-1)
                                      : site_pool[$urandom_range(0, 31)];
      if (w < 35)
        send_item(make_item(mle_pkg::KIND_EVENT, s, $urandom, $urandom, $urandom,
                            $urandom));
      else if (w < 55)
        send_item(make_item(mle_pkg::KIND_QUERY, s, $urandom, $urandom, $urandom,
                            $urandom));
      else if (w < 70)
        send_item(make_item(mle_pkg::KIND_SITE, s, $urandom, $urandom, $urandom,
                            $urandom));
      else if (w < 78)
        send_count(s, ($urandom_range(0, 9) < 7) ? $urandom_range(0, NNB) :
                      ($urandom_range(0, 1) ? $urandom_range(9, 15) : $urandom_range(0, 65535)));
      else if (w < 88)
        send_item(make_item(mle_pkg::KIND_NEIGH, s, $urandom_range(0, 7), pool_neighbor(),
                            $urandom, $urandom));
      else if (w < 93)
        send_item(make_item(mle_pkg::KIND_FACTOR, s, $urandom_range(0, 7),
                            $urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom,
                            $urandom, $urandom));
      else
        send_item(make_item($urandom_range(6, 7), $urandom, $urandom, $urandom,
                            $urandom, $urandom));
    end
  endtask

  // result checker; results last one cycle, so sample mid-cycle
  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer outcome=%0d", result_o.outcome);
        errors++;
      end else begin
        mle_pkg::mle_result_t e;
        e = expected_q.pop_front();
        if (result_o.outcome !== e.outcome) begin
          $error("outcome expected %0d actual %0d", e.outcome, result_o.outcome);
          errors++;
        end
        if (result_o.partner !== e.partner) begin
          $error("partner expected %0d actual %0d", e.partner, result_o.partner);
          errors++;
        end
        if (result_o.propensity !== e.propensity) begin
          $error("propensity expected %0h actual %0h", e.propensity, result_o.propensity);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(negedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int unsigned p = 0; p < 32; p++) site_pool[p] = $urandom_range(0, NSITE-1);
    zero_temp_m = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(200, 13, 1'b0);
    test_random(200, 78, 1'b1);
    test_random(200, 0, 1'b0);
    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      if (expected_q.size() != 0) $error("%0d results never arrived", expected_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/mle_pkg.sv
rtl/core/mle_wrap.sv
rtl/core/metropolis_lattice_exchange.sv
test/metropolis_lattice_exchange_tb.sv
